### rtl/matrix3x3_inverse_assert.svh
// ---------------------------------------------------------------------------
// matrix3x3_inverse assertion macros
// Clocked implication checks shared by the m3i_fifo and m3i_back modules.
// ---------------------------------------------------------------------------
`ifndef MATRIX3X3_INVERSE_ASSERT_SVH
`define MATRIX3X3_INVERSE_ASSERT_SVH

// Check that cons holds in the same cycle as ante
`define M3I_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante
`define M3I_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/m3i_pkg.sv
// ---------------------------------------------------------------------------
// m3i_pkg
// Widths, cofactor index tables and shared types of the 3x3 matrix inverse.
// ---------------------------------------------------------------------------
package m3i_pkg;

    localparam int unsigned N_ELEM       = 9;
    localparam int unsigned N_TERM       = 3;
    localparam int unsigned ELEM_W       = 32;
    localparam int unsigned PROD_W       = 64;
    localparam int unsigned COF_W        = 65;
    localparam int unsigned CM_W         = 64;
    localparam int unsigned DET_W        = 98;
    localparam int unsigned MAG_W        = 97;
    localparam int unsigned CMP_W        = MAG_W + 1;
    localparam int unsigned REM_W        = MAG_W;
    localparam int unsigned Q_W          = 33;
    localparam int unsigned DIV_STEPS    = 33;
    localparam int unsigned BACK_LAST    = DIV_STEPS + 1;
    localparam int unsigned FRONT_STAGES = 6;
    localparam int unsigned FIFO_DEPTH   = 4;
    localparam int unsigned FIFO_AW      = 2;
    localparam int unsigned FIFO_CW      = 3;

    typedef logic [3:0] t_idx;

    // cofactor k = d[A]*d[B] - d[C]*d[D], elements in column-major order
    localparam t_idx COF_A [N_ELEM] = '{4'd4, 4'd2, 4'd1, 4'd5, 4'd0, 4'd2, 4'd3, 4'd1, 4'd0};
    localparam t_idx COF_B [N_ELEM] = '{4'd8, 4'd7, 4'd5, 4'd6, 4'd8, 4'd3, 4'd7, 4'd6, 4'd4};
    localparam t_idx COF_C [N_ELEM] = '{4'd5, 4'd1, 4'd2, 4'd3, 4'd2, 4'd0, 4'd4, 4'd0, 4'd1};
    localparam t_idx COF_D [N_ELEM] = '{4'd7, 4'd8, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd7, 4'd3};

    // quotient clamp values for positive and negative results
    localparam logic [Q_W-1:0] LIM_POS = 33'h0_7FFF_FFFF;
    localparam logic [Q_W-1:0] LIM_NEG = 33'h0_8000_0000;

    typedef logic signed [ELEM_W-1:0]     t_elem;
    typedef logic [N_ELEM-1:0][ELEM_W-1:0] t_mat;

    // queued work for the divider: cofactor magnitudes, signs, |det|, singular flag
    typedef struct packed {
        logic [N_ELEM-1:0][CM_W-1:0] cm;
        logic [N_ELEM-1:0]           neg;
        logic [MAG_W-1:0]            dmag;
        logic                        singular;
    } t_qitem;

    typedef struct packed {
        t_mat inv;
        logic singular;
        logic saturated;
    } t_result;

endpackage

### rtl/m3i_front.sv
// ---------------------------------------------------------------------------
// m3i_front
// Accepts matrices, forms cofactors and determinant, classifies singular.
// ---------------------------------------------------------------------------
module m3i_front
    import m3i_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_mat   i_mat,
    input  logic   i_full,
    output logic   o_push,
    output t_qitem o_item
);

    logic [FRONT_STAGES-1:0] r_v;
    logic                    w_en;

    t_elem                    r_d    [N_ELEM];
    logic signed [PROD_W-1:0] r_pa   [N_ELEM];
    logic signed [PROD_W-1:0] r_pb   [N_ELEM];
    t_elem                    r_d2   [N_TERM];
    t_elem                    r_d3   [N_TERM];
    logic signed [COF_W-1:0]  r_cof3 [N_ELEM];
    logic signed [COF_W-1:0]  r_cof4 [N_ELEM];
    logic signed [COF_W-1:0]  r_cof5 [N_ELEM];
    logic signed [COF_W-1:0]  r_cof6 [N_ELEM];
    logic signed [COF_W-1:0]  r_plo  [N_TERM];
    logic signed [COF_W-1:0]  r_phi  [N_TERM];
    logic signed [DET_W-1:0]  r_term [N_TERM];
    logic signed [DET_W-1:0]  r_det;

    logic                     w_dneg;
    logic signed [DET_W-1:0]  w_dabs;

    // advance the whole front unless its last item cannot enter the queue
    assign w_en    = !r_v[FRONT_STAGES-1] || !i_full;
    assign o_ready = w_en;
    assign o_push  = r_v[FRONT_STAGES-1] && !i_full;

    // shift the stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[FRONT_STAGES-2:0], i_valid};
        end
    end

    // products, cofactors, partial products, terms, determinant
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < N_ELEM; k++) begin
                r_d[k]    <= i_mat[k];
                r_pa[k]   <= r_d[COF_A[k]] * r_d[COF_B[k]];
                r_pb[k]   <= r_d[COF_C[k]] * r_d[COF_D[k]];
                r_cof3[k] <= COF_W'(r_pa[k]) - COF_W'(r_pb[k]);
                r_cof4[k] <= r_cof3[k];
                r_cof5[k] <= r_cof4[k];
                r_cof6[k] <= r_cof5[k];
            end
            for (int t = 0; t < N_TERM; t++) begin
                r_d2[t]   <= r_d[t];
                r_d3[t]   <= r_d2[t];
                r_plo[t]  <= r_d3[t] * $signed({1'b0, r_cof3[3*t][31:0]});
                r_phi[t]  <= r_d3[t] * $signed(r_cof3[3*t][COF_W-1:32]);
                r_term[t] <= (DET_W'(r_phi[t]) <<< 32) + DET_W'(r_plo[t]);
            end
            r_det <= r_term[0] + r_term[1] + r_term[2];
        end
    end

    // split determinant and cofactors into magnitude and sign
    assign w_dneg = r_det[DET_W-1];
    assign w_dabs = w_dneg ? -r_det : r_det;

    always_comb begin
        o_item.dmag     = w_dabs[MAG_W-1:0];
        o_item.singular = (r_det == '0);
        for (int k = 0; k < N_ELEM; k++) begin
            o_item.cm[k]  = r_cof6[k][COF_W-1] ? CM_W'(-r_cof6[k]) : CM_W'(r_cof6[k]);
            o_item.neg[k] = r_cof6[k][COF_W-1] ^ w_dneg;
        end
    end

endmodule

### rtl/m3i_fifo.sv
// ---------------------------------------------------------------------------
// m3i_fifo
// Short queue between the cofactor front and the divider back.
// ---------------------------------------------------------------------------
`include "matrix3x3_inverse_assert.svh"

module m3i_fifo
    import m3i_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_qitem i_item,
    output logic   o_full,
    input  logic   i_pop,
    output t_qitem o_item,
    output logic   o_empty
);

    t_qitem               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr;
    logic [FIFO_AW-1:0]   r_rd;
    logic [FIFO_CW-1:0]   r_cnt;

    assign o_full  = (r_cnt == FIFO_CW'(FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_mem[r_rd];

    // move pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // store the pushed item
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    `M3I_ASSERT_NOW(a_no_overflow, i_clk, i_rst_n, i_push, !o_full, "push into full queue")
    `M3I_ASSERT_NOW(a_no_underflow, i_clk, i_rst_n, i_pop, !o_empty, "pop from empty queue")
    `M3I_ASSERT_NEXT(a_count_up, i_clk, i_rst_n, i_push && !i_pop, r_cnt == $past(r_cnt) + 1'b1, "count did not rise")

endmodule

### rtl/m3i_back.sv
// ---------------------------------------------------------------------------
// m3i_back
// Nine-lane pipelined restoring divider, saturation and output register.
// ---------------------------------------------------------------------------
`include "matrix3x3_inverse_assert.svh"

module m3i_back
    import m3i_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_pop,
    input  t_qitem  i_item,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    logic [BACK_LAST:0]  r_v;
    logic                w_en;

    logic [REM_W-1:0]    r_rem  [DIV_STEPS+1][N_ELEM];
    logic [Q_W-1:0]      r_q    [DIV_STEPS+1][N_ELEM];
    logic [N_ELEM-1:0]   r_neg  [DIV_STEPS+1];
    logic [N_ELEM-1:0]   r_satp [DIV_STEPS+1];
    logic [MAG_W-1:0]    r_dmag [DIV_STEPS+1];
    logic                r_sing [DIV_STEPS+1];
    logic [N_ELEM-1:0]   r_b0;
    t_result             r_res;

    logic [REM_W-1:0]    n_rem  [DIV_STEPS][N_ELEM];
    logic [Q_W-1:0]      n_q    [DIV_STEPS][N_ELEM];
    t_result             n_res;

    // advance unless the output holds an item not yet taken
    assign w_en     = !r_v[BACK_LAST] || i_ready;
    assign o_pop    = w_en && i_valid;
    assign o_valid  = r_v[BACK_LAST];
    assign o_result = r_res;

    // one quotient bit per stage and lane
    always_comb begin
        logic [REM_W-1:0] v_sh;
        logic             v_ge;
        for (int j = 0; j < DIV_STEPS; j++) begin
            for (int l = 0; l < N_ELEM; l++) begin
                v_sh = {r_rem[j][l][REM_W-2:0], (j == 0) ? r_b0[l] : 1'b0};
                v_ge = (v_sh >= r_dmag[j]);
                n_rem[j][l] = v_ge ? (v_sh - r_dmag[j]) : v_sh;
                n_q[j][l]   = {r_q[j][l][Q_W-2:0], v_ge};
            end
        end
    end

    // clamp, apply sign, force zero on a singular matrix
    always_comb begin
        logic [Q_W-1:0]    v_lim;
        logic [Q_W-1:0]    v_val;
        logic [ELEM_W-1:0] v_mag;
        logic              v_sat;
        logic              v_any;
        v_any = 1'b0;
        for (int l = 0; l < N_ELEM; l++) begin
            v_lim = r_neg[DIV_STEPS][l] ? LIM_NEG : LIM_POS;
            v_sat = r_satp[DIV_STEPS][l] || (r_q[DIV_STEPS][l] > v_lim);
            v_val = v_sat ? v_lim : r_q[DIV_STEPS][l];
            v_mag = v_val[ELEM_W-1:0];
            n_res.inv[l] = r_sing[DIV_STEPS] ? '0 :
                           (r_neg[DIV_STEPS][l] ? -v_mag : v_mag);
            v_any = v_any | v_sat;
        end
        n_res.singular  = r_sing[DIV_STEPS];
        n_res.saturated = v_any && !r_sing[DIV_STEPS];
    end

    // shift the stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[BACK_LAST-1:0], i_valid};
        end
    end

    // load, iterate and register the result
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int l = 0; l < N_ELEM; l++) begin
                r_rem[0][l]  <= REM_W'(i_item.cm[l][CM_W-1:1]);
                r_q[0][l]    <= '0;
                r_b0[l]      <= i_item.cm[l][0];
                r_satp[0][l] <= (CMP_W'(i_item.cm[l]) >= {i_item.dmag, 1'b0});
            end
            r_neg[0]  <= i_item.neg;
            r_dmag[0] <= i_item.dmag;
            r_sing[0] <= i_item.singular;
            for (int j = 0; j < DIV_STEPS; j++) begin
                for (int l = 0; l < N_ELEM; l++) begin
                    r_rem[j+1][l] <= n_rem[j][l];
                    r_q[j+1][l]   <= n_q[j][l];
                end
                r_neg[j+1]  <= r_neg[j];
                r_satp[j+1] <= r_satp[j];
                r_dmag[j+1] <= r_dmag[j];
                r_sing[j+1] <= r_sing[j];
            end
            r_res <= n_res;
        end
    end

    `M3I_ASSERT_NOW(a_sing_clean, i_clk, i_rst_n, r_v[BACK_LAST] && r_res.singular, !r_res.saturated && (r_res.inv == '0), "singular result not clean")
    `M3I_ASSERT_NEXT(a_pop_loads, i_clk, i_rst_n, o_pop, r_v[0], "popped item not loaded")
    `M3I_ASSERT_NEXT(a_drain, i_clk, i_rst_n, w_en && r_v[DIV_STEPS], r_v[BACK_LAST], "quotient lost before output")

endmodule

### rtl/matrix3x3_inverse.sv
// ---------------------------------------------------------------------------
// matrix3x3_inverse
// 3x3 Q16.16 matrix inverse by the adjugate method, streaming.
// ---------------------------------------------------------------------------
// Takes one matrix per cycle and returns one inverse per cycle unless the
// output stalls on m_axis_tready. Path: cofactor and determinant pipeline,
// the queue, a load stage, the restoring divider (one quotient bit per
// stage, nine lanes sharing |det|) and the output register. A zero
// determinant gives an all-zero matrix with singular set; otherwise a
// clamped element sets saturated.
module matrix3x3_inverse
    import m3i_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // col0_row0, col0_row1, col0_row2, col1_row0 .. col2_row2, 32 bits each
    input  logic [287:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // inv_col0_row0, inv_col0_row1 .. inv_col2_row2, 32 bits each
    output logic [287:0] m_axis_tdata,
    // singular, saturated
    output logic [1:0]   m_axis_tuser
);

    logic    w_push;
    logic    w_full;
    logic    w_pop;
    logic    w_empty;
    t_qitem  w_fitem;
    t_qitem  w_bitem;
    t_result w_res;

    m3i_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_mat   (s_axis_tdata),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_item  (w_fitem)
    );

    m3i_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_fitem),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_item  (w_bitem),
        .o_empty (w_empty)
    );

    m3i_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (!w_empty),
        .o_pop    (w_pop),
        .i_item   (w_bitem),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (w_res)
    );

    // pack the result item
    assign m_axis_tdata = w_res.inv;
    assign m_axis_tuser = {w_res.saturated, w_res.singular};

endmodule
